### design/fpd_pkg.sv
// shared types, constants and code points for the front panel bus frame decoder
// no dependencies
package fpd_pkg;

    localparam int MSG_WIDTH  = 14;
    localparam int HEAD_BYTES = 8;
    localparam int MSG_POS_W  = $clog2(MSG_WIDTH + 1);
    localparam int HEAD_IDX_W = $clog2(HEAD_BYTES);
    localparam int Q_DEPTH    = 2;

    localparam logic [7:0]  BYTE_EOF_OUT  = 8'hBB;
    localparam logic [7:0]  BYTE_BTN_OUT  = 8'h77;
    localparam logic [7:0]  BYTE_HDR_MASK = 8'h7F;
    localparam logic [7:0]  BYTE_BTN_END  = 8'h66;
    localparam logic [7:0]  BYTE_DOT      = 8'h84;
    localparam logic [7:0]  BYTE_COMMA    = 8'h86;
    localparam logic [7:0]  BYTE_COLON_A  = 8'h8C;
    localparam logic [7:0]  BYTE_COLON_B  = 8'h8D;
    localparam logic [7:0]  BYTE_SKIP     = 8'h81;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;
    localparam logic [7:0]  CHAR_COMMA    = 8'h2C;
    localparam logic [7:0]  CHAR_COLON    = 8'h3A;
    localparam logic [7:0]  CHAR_MINUS    = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [7:0]  CHAR_NINE     = 8'h39;
    localparam logic [15:0] ANN_KEEP_MASK = 16'hF7FF;
    localparam logic [15:0] ANN_SHIFT_BIT = 16'h0800;
    localparam logic [19:0] ELAPSED_MAX   = 20'hFFFFF;

    localparam logic [7:0]  RST_FRAME_LIMIT = 8'd100;
    localparam logic [19:0] RST_SHIFT_WIN   = 20'd300000;
    localparam logic [23:0] RST_SHIFT_CODE  = 24'd7839183;

    localparam logic [1:0] CFG_FRAME_LIMIT = 2'd0;
    localparam logic [1:0] CFG_SHIFT_WIN   = 2'd1;
    localparam logic [1:0] CFG_SHIFT_CODE  = 2'd2;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_ANN  = 2'd1;
    localparam logic [1:0] KIND_BAR  = 2'd2;

    typedef enum logic [2:0] {
        MODE_INIT    = 3'd0,
        MODE_UNKNOWN = 3'd1,
        MODE_MESSAGE = 3'd2,
        MODE_ANN     = 3'd3,
        MODE_CONTROL = 3'd4,
        MODE_BUTTON  = 3'd5
    } t_mode;

    typedef struct packed {
        logic       func;
        logic [7:0] in_byte;
        logic [7:0] out_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  char_index;
        logic [7:0]  char_code;
        logic [15:0] ann_word;
        logic [14:0] bar_value;
        logic        bar_style;
        logic        final_res;
    } t_out_item;

    typedef struct packed {
        logic                        is_ann;
        logic [MSG_WIDTH-1:0][7:0]   chars;
        logic [5:0][7:0]             head;
        logic [15:0]                 ann;
    } t_job;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

endpackage

### design/fpd_front.sv
// frame front end: config registers, frame sorting, message field, annunciator and shift
// depends on fpd_pkg; hands publish jobs to the job queue
module fpd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_accept,
    input  fpd_pkg::t_in_item  i_item,
    output logic               o_job_valid,
    output fpd_pkg::t_job      o_job
);

    logic [7:0]  r_limit;
    logic [19:0] r_win;
    logic [23:0] r_code;

    fpd_pkg::t_mode r_mode, n_mode;
    logic [7:0]  r_len, n_len;
    logic [fpd_pkg::HEAD_BYTES-1:0][7:0] r_head_in, n_head_in;
    logic [2:0][7:0] r_head_out, n_head_out;
    logic [fpd_pkg::MSG_WIDTH-1:0][7:0] r_chars, n_chars;
    logic [fpd_pkg::MSG_POS_W-1:0] r_pos, n_pos;
    logic        r_fresh, n_fresh;
    logic [15:0] r_ann, n_ann;
    logic        r_sh_act, n_sh_act;
    logic        r_sh_odd, n_sh_odd;
    logic [19:0] r_elapsed, n_elapsed;

    logic        w_pair;
    logic [7:0]  w_ib, w_ob;
    logic        w_eof;
    logic [7:0]  w_len_inc;
    logic        w_end;
    logic [15:0] w_annw;
    logic [19:0] w_el_inc;
    logic [7:0]  w_ch;
    logic        w_drop;

    assign w_pair    = i_accept && !i_item.func;
    assign w_ib      = i_item.in_byte;
    assign w_ob      = i_item.out_byte;
    assign w_eof     = (w_ib == 8'h00) && (w_ob == fpd_pkg::BYTE_EOF_OUT);
    assign w_len_inc = r_len + 8'd1;

    always_comb begin
        n_head_in  = r_head_in;
        n_head_out = r_head_out;
        if (w_pair) begin
            if (r_len < 8'(fpd_pkg::HEAD_BYTES)) begin
                n_head_in[r_len[fpd_pkg::HEAD_IDX_W-1:0]] = w_ib;
            end
            if (r_len < 8'd3) begin
                n_head_out[r_len[1:0]] = w_ob;
            end
        end
    end

    // next frame mode
    always_comb begin
        n_mode = r_mode;
        w_end  = 1'b0;
        if (w_pair) begin
            case (r_mode)
                fpd_pkg::MODE_INIT,
                fpd_pkg::MODE_MESSAGE,
                fpd_pkg::MODE_ANN,
                fpd_pkg::MODE_CONTROL: begin
                    w_end = w_eof;
                end
                fpd_pkg::MODE_UNKNOWN: begin
                    if (w_len_inc == 8'd1 && n_head_in[0] == 8'h00
                            && n_head_out[0] == fpd_pkg::BYTE_BTN_OUT) begin
                        n_mode = fpd_pkg::MODE_BUTTON;
                    end else if (w_len_inc == 8'd2) begin
                        if (n_head_in[0] == 8'h00 && (n_head_in[1] & fpd_pkg::BYTE_HDR_MASK)
                                == fpd_pkg::BYTE_HDR_MASK) begin
                            n_mode = fpd_pkg::MODE_MESSAGE;
                        end else if ((n_head_in[0] & fpd_pkg::BYTE_HDR_MASK)
                                == fpd_pkg::BYTE_HDR_MASK && n_head_in[1] == 8'h00) begin
                            n_mode = fpd_pkg::MODE_ANN;
                        end else begin
                            n_mode = fpd_pkg::MODE_CONTROL;
                        end
                    end
                end
                fpd_pkg::MODE_BUTTON: begin
                    w_end = (w_ib == fpd_pkg::BYTE_BTN_END);
                end
                default: begin
                    w_end = 1'b1;
                end
            endcase
            if (w_end) begin
                n_mode = fpd_pkg::MODE_UNKNOWN;
                n_len  = 8'd0;
            end else begin
                n_len = w_len_inc;
            end
            if (n_len >= r_limit) begin
                n_mode = fpd_pkg::MODE_UNKNOWN;
                n_len  = 8'd0;
            end
        end else begin
            n_len = r_len;
        end
    end

    // message byte mapping
    always_comb begin
        w_drop = 1'b0;
        if (w_ib == fpd_pkg::BYTE_DOT) begin
            w_ch = fpd_pkg::CHAR_DOT;
        end else if (w_ib == fpd_pkg::BYTE_COMMA) begin
            w_ch = fpd_pkg::CHAR_COMMA;
        end else if (w_ib == fpd_pkg::BYTE_COLON_A || w_ib == fpd_pkg::BYTE_COLON_B) begin
            w_ch = fpd_pkg::CHAR_COLON;
        end else begin
            w_ch   = w_ib;
            w_drop = (w_ib == fpd_pkg::BYTE_SKIP) || (w_ib == 8'h00);
        end
    end

    assign w_annw = ({n_head_in[3], n_head_in[2]} & fpd_pkg::ANN_KEEP_MASK)
                  | (r_ann & fpd_pkg::ANN_SHIFT_BIT);
    assign w_el_inc = (r_elapsed < fpd_pkg::ELAPSED_MAX) ? r_elapsed + 20'd1 : r_elapsed;

    // data actions and publish jobs
    always_comb begin
        n_chars     = r_chars;
        n_pos       = r_pos;
        n_fresh     = r_fresh;
        n_ann       = r_ann;
        n_sh_act    = r_sh_act;
        n_sh_odd    = r_sh_odd;
        n_elapsed   = r_elapsed;
        o_job_valid = 1'b0;
        o_job       = '0;
        o_job.chars = r_chars;
        for (int i = 0; i < 6; i++) begin
            o_job.head[i] = n_head_in[i + 2];
        end
        if (i_accept && i_item.func) begin
            if (r_sh_act) begin
                if (w_el_inc > r_win) begin
                    if (r_sh_odd) begin
                        n_ann       = r_ann ^ fpd_pkg::ANN_SHIFT_BIT;
                        o_job_valid = 1'b1;
                        o_job.is_ann = 1'b1;
                        o_job.ann    = r_ann ^ fpd_pkg::ANN_SHIFT_BIT;
                    end
                    n_sh_odd  = 1'b0;
                    n_sh_act  = 1'b0;
                    n_elapsed = 20'd0;
                end else begin
                    n_elapsed = w_el_inc;
                end
            end
        end else if (w_pair) begin
            case (r_mode)
                fpd_pkg::MODE_MESSAGE: begin
                    if (w_eof) begin
                        o_job_valid = 1'b1;
                        n_fresh     = 1'b1;
                    end else begin
                        if (r_fresh) begin
                            n_chars = {fpd_pkg::MSG_WIDTH{fpd_pkg::CHAR_SPACE}};
                            n_pos   = '0;
                            n_fresh = 1'b0;
                        end
                        if (!w_drop && n_pos < fpd_pkg::MSG_POS_W'(fpd_pkg::MSG_WIDTH)) begin
                            n_chars[n_pos] = w_ch;
                            n_pos          = n_pos + 1'b1;
                        end
                    end
                end
                fpd_pkg::MODE_ANN: begin
                    if (w_eof && w_len_inc >= 8'd4 && w_annw != r_ann) begin
                        n_ann        = w_annw;
                        o_job_valid  = 1'b1;
                        o_job.is_ann = 1'b1;
                        o_job.ann    = w_annw;
                    end
                end
                fpd_pkg::MODE_BUTTON: begin
                    if (w_ib == fpd_pkg::BYTE_BTN_END && w_len_inc >= 8'd3
                            && {n_head_out[0], n_head_out[1], n_head_out[2]} == r_code) begin
                        if (!r_sh_act) begin
                            n_sh_act = 1'b1;
                            n_sh_odd = 1'b1;
                        end else begin
                            n_sh_odd = !r_sh_odd;
                        end
                        n_elapsed = 20'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= fpd_pkg::RST_FRAME_LIMIT;
            r_win      <= fpd_pkg::RST_SHIFT_WIN;
            r_code     <= fpd_pkg::RST_SHIFT_CODE;
            r_mode     <= fpd_pkg::MODE_INIT;
            r_len      <= 8'd0;
            r_head_in  <= '0;
            r_head_out <= '0;
            r_chars    <= {fpd_pkg::MSG_WIDTH{fpd_pkg::CHAR_SPACE}};
            r_pos      <= '0;
            r_fresh    <= 1'b1;
            r_ann      <= 16'd0;
            r_sh_act   <= 1'b0;
            r_sh_odd   <= 1'b0;
            r_elapsed  <= 20'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fpd_pkg::CFG_FRAME_LIMIT: r_limit <= i_cfg_data[7:0];
                    fpd_pkg::CFG_SHIFT_WIN:   r_win   <= i_cfg_data[19:0];
                    fpd_pkg::CFG_SHIFT_CODE:  r_code  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_mode     <= n_mode;
            r_len      <= n_len;
            r_head_in  <= n_head_in;
            r_head_out <= n_head_out;
            r_chars    <= n_chars;
            r_pos      <= n_pos;
            r_fresh    <= n_fresh;
            r_ann      <= n_ann;
            r_sh_act   <= n_sh_act;
            r_sh_odd   <= n_sh_odd;
            r_elapsed  <= n_elapsed;
        end
    end

endmodule

### design/fpd_queue.sv
// two-entry job queue between the frame front end and the result sequencer
// depends on fpd_pkg
module fpd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  fpd_pkg::t_job i_data,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_valid,
    output fpd_pkg::t_job o_data
);

    fpd_pkg::t_job r_mem [fpd_pkg::Q_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'(fpd_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= !r_wp;
            end
            if (i_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### design/fpd_back.sv
// result sequencer: walks a job into character, bar-graph and annunciator items
// depends on fpd_pkg; parses the bar value one header byte per cycle
module fpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  fpd_pkg::t_job     i_job,
    output logic              o_job_done,
    output logic              o_empty,
    input  logic              i_pop,
    output fpd_pkg::t_out_item o_item
);

    logic [fpd_pkg::MSG_POS_W-1:0] r_idx;
    logic        r_pinit;
    logic [3:0]  r_ppos;
    logic [13:0] r_val;
    logic [2:0]  r_cnt;
    logic [15:0] r_bar;
    logic        r_bstyle;

    logic        w_style;
    logic [2:0]  w_limit;
    logic [7:0]  w_b;
    logic [15:0] w_v16;
    logic        w_bar_emit;
    logic        w_pdone;
    logic        w_last_char;
    logic        w_take;

    assign w_style    = !fpd_pkg::is_digit(i_job.head[0]);
    assign w_limit    = w_style ? 3'd3 : 3'd4;
    assign w_b        = i_job.head[3'(r_ppos - 4'd2)];
    assign w_pdone    = r_pinit && (r_ppos == 4'd8);
    assign w_v16      = (w_style && i_job.head[0] == fpd_pkg::CHAR_MINUS)
                      ? 16'd0 - {2'b00, r_val} : {2'b00, r_val};
    assign w_bar_emit = (w_style != r_bstyle) || (w_v16 != r_bar);
    assign w_last_char = (r_idx == fpd_pkg::MSG_POS_W'(fpd_pkg::MSG_WIDTH - 1));

    assign o_empty = !i_job_valid || (!i_job.is_ann && w_last_char && !w_pdone);
    assign w_take  = i_pop && !o_empty;

    always_comb begin
        o_item     = '0;
        o_job_done = 1'b0;
        if (i_job.is_ann) begin
            o_item.kind      = fpd_pkg::KIND_ANN;
            o_item.ann_word  = i_job.ann;
            o_item.final_res = 1'b1;
            o_job_done       = w_take;
        end else if (r_idx < fpd_pkg::MSG_POS_W'(fpd_pkg::MSG_WIDTH)) begin
            o_item.kind       = fpd_pkg::KIND_CHAR;
            o_item.char_index = 4'(r_idx);
            o_item.char_code  = i_job.chars[r_idx];
            o_item.final_res  = w_last_char && !w_bar_emit;
            o_job_done        = w_take && w_last_char && !w_bar_emit;
        end else begin
            o_item.kind      = fpd_pkg::KIND_BAR;
            o_item.bar_value = w_v16[14:0];
            o_item.bar_style = w_style;
            o_item.final_res = 1'b1;
            o_job_done       = w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pinit  <= 1'b0;
            r_ppos   <= 4'd0;
            r_val    <= 14'd0;
            r_cnt    <= 3'd0;
            r_bar    <= 16'd0;
            r_bstyle <= 1'b0;
        end else begin
            if (o_job_done) begin
                r_idx   <= '0;
                r_pinit <= 1'b0;
                if (!i_job.is_ann) begin
                    r_bar    <= w_v16;
                    r_bstyle <= w_style;
                end
            end else begin
                if (w_take) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (i_job_valid && !i_job.is_ann) begin
                    if (!r_pinit) begin
                        r_pinit <= 1'b1;
                        r_ppos  <= w_style ? 4'd3 : 4'd2;
                        r_val   <= 14'd0;
                        r_cnt   <= 3'd0;
                    end else if (r_ppos != 4'd8) begin
                        r_ppos <= r_ppos + 4'd1;
                        if (fpd_pkg::is_digit(w_b) && r_cnt < w_limit) begin
                            r_val <= (r_val << 3) + (r_val << 1)
                                   + {10'd0, w_b[3:0]};
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

### design/front_panel_bus_frame_decoder.sv
// top level of the front panel bus frame decoder
// depends on fpd_pkg, fpd_front, fpd_queue and fpd_back
//
// input side is a queue: write an item (byte pair or microsecond tick) with push
// while full is low. output side is a queue: a result sits on o_out_item while
// empty is low and leaves with pop. final_res marks the last result of an input.
// the front end takes one item per cycle while full is low and updates frame
// state at once; items that publish something leave a job in a two-entry queue.
// a message job gives 14 character results and possibly a bar result, one per
// cycle while pop is high, but the last character waits for the bar value to
// be parsed; an annunciator job gives one result. the bar value is parsed from
// the header while the characters are read out. when pop stays low the job
// queue fills and full rises after two pending jobs; items without results
// still pass while a slot is free. configuration writes are always ready.
// synchronous reset returns the registers to their defaults, clears the queue
// and puts the frame machine back to waiting for the end-of-frame pair.
module front_panel_bus_frame_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  fpd_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output fpd_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    logic          w_accept;
    logic          w_job_valid;
    fpd_pkg::t_job w_job;
    logic          w_q_valid;
    fpd_pkg::t_job w_q_data;
    logic          w_done;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    fpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    fpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_job_valid),
        .i_data  (w_job),
        .i_rd    (w_done),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    fpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_data),
        .o_job_done  (w_done),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule
